[hdl/cvf_pkg.sv]
`default_nettype none

package cvf_pkg;

  localparam int CV_W            = 16;
  localparam int CV_FRAC_BITS    = 11;
  localparam int OCT_W           = 4;   // octave index, up to 16 octaves
  localparam int ENTRY_W         = 32;  // Q2.30, top entry is exactly 2.0
  localparam int FREQ_W          = 23;
  localparam int SCALED_W        = 44;  // 12-bit base times 32-bit mantissa

  localparam int NUM_OCTAVES_DEF     = 11;
  localparam int FRAC_TABLE_BITS_DEF = 6;

  localparam logic [11:0]       BASE_A_Q8 = 12'd3520;  // 13.75 Hz, 8 fraction bits
  localparam logic [FREQ_W-1:0] FREQ_MAX  = '1;

  // pipeline load enables, one per register stage
  typedef struct packed {
    logic ld_in;
    logic ld_s2;
    logic ld_s3;
    logic ld_out;
  } cvf_ctrl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    b   = 64'd1 << 62;
    rem = x;
    for (int k = 0; k < 32; k++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(i / 2^bits) in Q2.30, evaluated at elaboration only
  function automatic logic [ENTRY_W-1:0] exp_entry(input int i, input int bits);
    logic [63:0] roots [0:10];
    logic [63:0] acc;
    acc = 64'd1 << 30;
    if (i >= (1 << bits)) begin
      return ENTRY_W'(64'd1 << 31);
    end
    roots[0] = 64'd1 << 31;
    for (int j = 1; j <= 10; j++) begin
      roots[j] = isqrt64(roots[j-1] << 30);
    end
    for (int j = 1; j <= 10; j++) begin
      if (j <= bits && ((i >> (bits - j)) & 1) == 1) begin
        acc = (acc * roots[j] + (64'd1 << 29)) >> 30;
      end
    end
    return ENTRY_W'(acc);
  endfunction

endpackage

`default_nettype wire

[hdl/cvf_exp_table.sv]
`default_nettype none

// Constant 2^x table, read at an entry and its upper neighbor.
module cvf_exp_table #(
  parameter int FRAC_TABLE_BITS = cvf_pkg::FRAC_TABLE_BITS_DEF
) (
  input  wire logic [FRAC_TABLE_BITS-1:0]   idx,
  output logic      [cvf_pkg::ENTRY_W-1:0]  lo,
  output logic      [cvf_pkg::ENTRY_W-1:0]  hi
);

  localparam int TBL_N = (1 << FRAC_TABLE_BITS) + 1;

  logic [cvf_pkg::ENTRY_W-1:0] tbl [0:TBL_N-1];
  logic [FRAC_TABLE_BITS:0]    idx_hi;

  for (genvar g = 0; g < TBL_N; g++) begin : g_entry
    localparam logic [cvf_pkg::ENTRY_W-1:0] VAL = cvf_pkg::exp_entry(g, FRAC_TABLE_BITS);
    assign tbl[g] = VAL;
  end

  assign idx_hi = {1'b0, idx} + {{FRAC_TABLE_BITS{1'b0}}, 1'b1};
  assign lo     = tbl[{1'b0, idx}];
  assign hi     = tbl[idx_hi];

endmodule

`default_nettype wire

[hdl/cvf_datapath.sv]
`default_nettype none

// Four register stages: input, interpolation product, scaled mantissa, result.
module cvf_datapath #(
  parameter int NUM_OCTAVES     = cvf_pkg::NUM_OCTAVES_DEF,
  parameter int FRAC_TABLE_BITS = cvf_pkg::FRAC_TABLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire cvf_pkg::cvf_ctrl_t           ctrl,
  input  wire logic [cvf_pkg::CV_W-1:0]     cv,
  output logic      [cvf_pkg::FREQ_W-1:0]   freq,
  output logic                              oor
);

  localparam int RSHIFT = cvf_pkg::CV_FRAC_BITS - FRAC_TABLE_BITS;
  localparam int PROD_W = cvf_pkg::ENTRY_W + RSHIFT;
  localparam int EW     = cvf_pkg::ENTRY_W;
  localparam int OW     = cvf_pkg::OCT_W;
  localparam int SW     = cvf_pkg::SCALED_W;
  localparam logic signed [cvf_pkg::CV_W-1:0] TOP_CV =
    cvf_pkg::CV_W'((NUM_OCTAVES - 1) << cvf_pkg::CV_FRAC_BITS);
  localparam logic [cvf_pkg::CV_W-1:0] QUARTER_V =
    cvf_pkg::CV_W'(1 << (cvf_pkg::CV_FRAC_BITS - 2));

  // stage 1: input register
  logic signed [cvf_pkg::CV_W-1:0] cv_q;
  logic [cvf_pkg::CV_W-1:0]        w1;
  logic                            oor1;
  logic [OW-1:0]                   oct1;
  logic [FRAC_TABLE_BITS-1:0]      idx1;
  logic [RSHIFT-1:0]               rem1;
  logic [EW-1:0]                   e_lo;
  logic [EW-1:0]                   e_hi;
  logic [PROD_W-1:0]               prod1;

  // stage 2
  logic [EW-1:0]     e0_s2;
  logic [PROD_W-1:0] prod_s2;
  logic [OW-1:0]     oct_s2;
  logic              oor_s2;
  logic [PROD_W-1:0] rnd2;
  logic [EW-1:0]     m2;
  logic [SW-1:0]     scaled2;

  // stage 3
  logic [SW-1:0] sc_s3;
  logic [OW-1:0] oct_s3;
  logic          oor_s3;
  logic [4:0]    rnd_sh3;
  logic [4:0]    sh3;
  logic [SW:0]   sum3;
  logic [SW:0]   f3;
  logic [cvf_pkg::FREQ_W-1:0] freq3;

  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      cv_q <= cv;
    end
  end

  // w = v + 0.25 V puts note A on the octave boundary
  always_comb begin
    oor1  = cv_q[cvf_pkg::CV_W-1] || (cv_q > TOP_CV);
    w1    = cv_q + QUARTER_V;
    oct1  = w1[cvf_pkg::CV_FRAC_BITS +: OW];
    idx1  = w1[cvf_pkg::CV_FRAC_BITS-1:RSHIFT];
    rem1  = w1[RSHIFT-1:0];
    prod1 = PROD_W'(e_hi - e_lo) * PROD_W'(rem1);
  end

  cvf_exp_table #(
    .FRAC_TABLE_BITS(FRAC_TABLE_BITS)
  ) u_table (
    .idx(idx1),
    .lo (e_lo),
    .hi (e_hi)
  );

  always_ff @(posedge clk) begin
    if (ctrl.ld_s2) begin
      e0_s2   <= e_lo;
      prod_s2 <= prod1;
      oct_s2  <= oct1;
      oor_s2  <= oor1;
    end
  end

  always_comb begin
    rnd2    = prod_s2 + PROD_W'(1 << (RSHIFT - 1));
    m2      = e0_s2 + EW'(rnd2 >> RSHIFT);
    scaled2 = SW'(cvf_pkg::BASE_A_Q8) * SW'(m2);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_s3) begin
      sc_s3  <= scaled2;
      oct_s3 <= oct_s2;
      oor_s3 <= oor_s2;
    end
  end

  // Q2.30 times base, back to Q.8: shift right by 30 - octave, rounded
  always_comb begin
    rnd_sh3 = 5'd29 - {1'b0, oct_s3};
    sh3     = 5'd30 - {1'b0, oct_s3};
    sum3    = {1'b0, sc_s3} + ((SW+1)'(1) << rnd_sh3);
    f3      = sum3 >> sh3;
    if (oor_s3) begin
      freq3 = '0;
    end else if (f3 > (SW+1)'(cvf_pkg::FREQ_MAX)) begin
      freq3 = cvf_pkg::FREQ_MAX;
    end else begin
      freq3 = f3[cvf_pkg::FREQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      freq <= freq3;
      oor  <= oor_s3;
    end
  end

endmodule

`default_nettype wire

[hdl/cv_to_frequency_converter_core.sv]
// Channel   Dir  tdata                         tuser
// s_*       in   [15:0] control_voltage Q5.11  -
// m_*       out  [22:0] frequency_hz Q.8       [0] out_of_range
//
// m_tvalid rises once the accepted input word has passed the input, product,
// scaled and output registers; with m_tready high the result word is taken.
// One word per cycle while m_tready does not stall the output; the interpolation
// multiply and the base-frequency multiply each sit in a stage of their own.
// Each stage loads when empty or when the next one moves, so bubbles are
// filled during an output stall and s_tready falls only with all stages full.
// rst clears the valid bits only.
`default_nettype none

module cv_to_frequency_converter_core #(
  parameter int NUM_OCTAVES     = cvf_pkg::NUM_OCTAVES_DEF,
  parameter int FRAC_TABLE_BITS = cvf_pkg::FRAC_TABLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] control_voltage
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [22:0] frequency_hz, [23] zero
  output logic [0:0]       m_tuser    // [0] out_of_range
);

  cvf_pkg::cvf_ctrl_t          ctrl;
  logic                        v1;
  logic                        v2;
  logic                        v3;
  logic                        vo;
  logic [cvf_pkg::FREQ_W-1:0]  freq;
  logic                        oor;

  always_comb begin
    ctrl.ld_out = !vo || m_tready;
    ctrl.ld_s3  = !v3 || ctrl.ld_out;
    ctrl.ld_s2  = !v2 || ctrl.ld_s3;
    ctrl.ld_in  = !v1 || ctrl.ld_s2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (ctrl.ld_in) begin
        v1 <= s_tvalid;
      end
      if (ctrl.ld_s2) begin
        v2 <= v1;
      end
      if (ctrl.ld_s3) begin
        v3 <= v2;
      end
      if (ctrl.ld_out) begin
        vo <= v3;
      end
    end
  end

  cvf_datapath #(
    .NUM_OCTAVES    (NUM_OCTAVES),
    .FRAC_TABLE_BITS(FRAC_TABLE_BITS)
  ) u_datapath (
    .clk (clk),
    .ctrl(ctrl),
    .cv  (s_tdata),
    .freq(freq),
    .oor (oor)
  );

  assign s_tready = ctrl.ld_in;
  assign m_tvalid = vo;
  assign m_tdata  = {1'b0, freq};
  assign m_tuser  = oor;

`ifndef NO_ASSERTIONS
  // input side only stalls when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && vo))
    else $error("input stalled with an empty stage");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 24'd0))
    else $error("out-of-range word with nonzero frequency");

  // lowest valid voltage still maps to about 16 Hz
  a_valid_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[22:0] != 23'd0))
    else $error("in-range word with zero frequency");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (vo && m_tready && !v3) |=> !m_tvalid)
    else $error("result word repeated");
`endif

endmodule

`default_nettype wire
